// ===== rtl/normalized_quaternion_multiply_macros.svh =====
// Assertion macros for the quaternion multiply block.
`ifndef NORMALIZED_QUATERNION_MULTIPLY_MACROS_SVH
`define NORMALIZED_QUATERNION_MULTIPLY_MACROS_SVH
`ifndef SYNTHESIS
`define NQM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("nqm: assertion failed");
`define NQM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("nqm: implication failed");
`else
`define NQM_ASSERT(lbl, prop)
`define NQM_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ===== rtl/nqm_pkg.sv =====
package nqm_pkg;

	localparam int OUT_W      = 16;
	localparam int FRAC_SHIFT = 30;
	localparam int Q_W        = FRAC_SHIFT + 1;  // quotient bits of 2^30*H^2/M
	localparam int C_W        = 15;              // result magnitude search bits
	localparam int ODD_W      = C_W + 1;
	localparam int SQ_W       = 2 * ODD_W;

	localparam logic [OUT_W-1:0] UNIT_MAG = OUT_W'(16384);
	localparam logic signed [OUT_W-1:0] UNIT_POS = 16'sd16384;
	localparam logic signed [OUT_W-1:0] UNIT_NEG = -16'sd16384;

	// Hamilton product terms: q index, p index, subtract flag
	localparam logic [1:0] HAM_Q [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd3, 2'd1, 2'd2}
	};
	localparam logic [1:0] HAM_P [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd0, 2'd3, 2'd1},
		'{2'd3, 2'd0, 2'd2, 2'd1}
	};
	localparam logic HAM_NEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b1}
	};

	typedef struct packed {
		logic neg;
		logic zn;
	} lane_tag_t;

endpackage

// ===== rtl/nqm_pair_if.sv =====
interface nqm_pair_if #(parameter int W = 16) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] q_w, q_x, q_y, q_z;
	logic signed [W-1:0] p_w, p_x, p_y, p_z;

	modport source (output valid, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, input ready);
	modport sink (input valid, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, output ready);
endinterface

// ===== rtl/nqm_prod_if.sv =====
interface nqm_prod_if ();
	logic valid;
	logic ready;
	logic signed [15:0] r_w, r_x, r_y, r_z;
	logic zero_norm;

	modport source (output valid, r_w, r_x, r_y, r_z, zero_norm, input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, zero_norm, output ready);
endinterface

// ===== rtl/nqm_front.sv =====
module nqm_front import nqm_pkg::*; #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic signed [W-1:0] q [4],
	input  logic signed [W-1:0] p [4],
	output logic                out_vld,
	output logic [4*W:0]        m,
	output logic [4*W:0]        h2 [4],
	output lane_tag_t           tag [4]
);

	localparam int PW = 2 * W;
	localparam int HW = 2 * W + 2;
	localparam int MW = 2 * W + 1;
	localparam int LW = W + 1;
	localparam int NW = 4 * W + 1;
	localparam int SW = 4 * W + 2;

	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [PW-1:0] sqq_s1 [4];
	logic signed [PW-1:0] sqp_s1 [4];
	logic                 vld_s1;

	logic signed [HW-1:0] h_s2 [4];
	logic [MW-1:0]        nq_s2, np_s2;
	logic                 vld_s2;

	logic [MW-1:0]        hmag_s3 [4];
	lane_tag_t            tag_s3 [4];
	logic [MW-1:0]        nq_s3, np_s3;
	logic                 vld_s3;

	// split products: low part LW bits, high part W bits
	logic [2*LW-1:0]      m_ll_s4;
	logic [LW+W-1:0]      m_lh_s4, m_hl_s4;
	logic [2*W-1:0]       m_hh_s4;
	logic [2*LW-1:0]      h_ll_s4 [4];
	logic [LW+W-1:0]      h_lh_s4 [4];
	logic [2*W-1:0]       h_hh_s4 [4];
	lane_tag_t            tag_s4 [4];
	logic                 vld_s4;

	logic [NW-1:0]        m_s5;
	logic [NW-1:0]        h2_s5 [4];
	lane_tag_t            tag_s5 [4];
	logic                 vld_s5;

	logic signed [HW-1:0] h_sum [4];
	logic [MW-1:0]        nq_sum, np_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		logic signed [HW-1:0] acc;
		logic signed [HW-1:0] term;
		for (int k = 0; k < 4; k++) begin
			acc = '0;
			for (int i = 0; i < 4; i++) begin
				term = HW'(prod_s1[HAM_Q[k][i]][HAM_P[k][i]]);
				acc  = HAM_NEG[k][i] ? acc - term : acc + term;
			end
			h_sum[k] = acc;
		end
		nq_sum = '0;
		np_sum = '0;
		for (int i = 0; i < 4; i++) begin
			nq_sum = nq_sum + MW'($unsigned(sqq_s1[i]));
			np_sum = np_sum + MW'($unsigned(sqp_s1[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= PW'(q[i] * p[j]);
				end
				sqq_s1[i] <= PW'(q[i] * q[i]);
				sqp_s1[i] <= PW'(p[i] * p[i]);
			end

			h_s2  <= h_sum;
			nq_s2 <= nq_sum;
			np_s2 <= np_sum;

			for (int k = 0; k < 4; k++) begin
				hmag_s3[k]    <= MW'(h_s2[k][HW-1] ? -h_s2[k] : h_s2[k]);
				tag_s3[k].neg <= h_s2[k][HW-1];
				tag_s3[k].zn  <= (nq_s2 == '0) || (np_s2 == '0);
			end
			nq_s3 <= nq_s2;
			np_s3 <= np_s2;

			m_ll_s4 <= (2*LW)'(nq_s3[LW-1:0]) * (2*LW)'(np_s3[LW-1:0]);
			m_lh_s4 <= (LW+W)'(nq_s3[LW-1:0]) * (LW+W)'(np_s3[MW-1:LW]);
			m_hl_s4 <= (LW+W)'(nq_s3[MW-1:LW]) * (LW+W)'(np_s3[LW-1:0]);
			m_hh_s4 <= (2*W)'(nq_s3[MW-1:LW]) * (2*W)'(np_s3[MW-1:LW]);
			for (int k = 0; k < 4; k++) begin
				h_ll_s4[k] <= (2*LW)'(hmag_s3[k][LW-1:0]) * (2*LW)'(hmag_s3[k][LW-1:0]);
				h_lh_s4[k] <= (LW+W)'(hmag_s3[k][LW-1:0]) * (LW+W)'(hmag_s3[k][MW-1:LW]);
				h_hh_s4[k] <= (2*W)'(hmag_s3[k][MW-1:LW]) * (2*W)'(hmag_s3[k][MW-1:LW]);
			end
			tag_s4 <= tag_s3;

			m_s5 <= NW'((SW'(m_hh_s4) << (2*LW))
				+ ((SW'(m_lh_s4) + SW'(m_hl_s4)) << LW)
				+ SW'(m_ll_s4));
			for (int k = 0; k < 4; k++) begin
				h2_s5[k] <= NW'((SW'(h_hh_s4[k]) << (2*LW))
					+ (SW'(h_lh_s4[k]) << (LW + 1))
					+ SW'(h_ll_s4[k]));
			end
			tag_s5 <= tag_s4;
		end
	end

	assign out_vld = vld_s5;
	assign m       = m_s5;
	assign h2      = h2_s5;
	assign tag     = tag_s5;

endmodule

// ===== rtl/nqm_div.sv =====
module nqm_div import nqm_pkg::*; #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [4*W:0]   num,
	input  logic [4*W:0]   den,
	input  lane_tag_t      in_tag,
	output logic           out_vld,
	output logic [Q_W-1:0] quo,
	output lane_tag_t      out_tag
);

	localparam int NW = 4 * W + 1;

	// restoring division, one quotient bit per stage; num <= den
	logic [NW-1:0]  rem_s [Q_W];
	logic [NW-1:0]  den_s [Q_W];
	logic [Q_W-1:0] quo_s [Q_W];
	lane_tag_t      tag_s [Q_W];
	logic [Q_W-1:0] vld_s;

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic [NW:0]    trial;
		logic [NW:0]    diff;
		logic [NW-1:0]  dn;
		logic [Q_W-1:0] qprev;
		lane_tag_t      tprev;
		logic           vprev;
		logic           ge;

		if (g == 0) begin : g_first
			assign trial = {1'b0, num};
			assign dn    = den;
			assign qprev = '0;
			assign tprev = in_tag;
			assign vprev = in_vld;
		end else begin : g_next
			assign trial = {rem_s[g-1], 1'b0};
			assign dn    = den_s[g-1];
			assign qprev = quo_s[g-1];
			assign tprev = tag_s[g-1];
			assign vprev = vld_s[g-1];
		end

		assign ge   = trial >= {1'b0, dn};
		assign diff = trial - {1'b0, dn};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vprev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? diff[NW-1:0] : trial[NW-1:0];
				den_s[g] <= dn;
				quo_s[g] <= {qprev[Q_W-2:0], ge};
				tag_s[g] <= tprev;
			end
		end
	end

	assign out_vld = vld_s[Q_W-1];
	assign quo     = quo_s[Q_W-1];
	assign out_tag = tag_s[Q_W-1];

endmodule

// ===== rtl/nqm_sqrt.sv =====
module nqm_sqrt import nqm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [Q_W-1:0] t,
	input  lane_tag_t      in_tag,
	output logic           out_vld,
	output logic [C_W-1:0] mag,
	output lane_tag_t      out_tag
);

	// largest c with (2c-1)^2 <= t, one bit per stage from the top
	logic [C_W-1:0] mg_s  [C_W];
	logic [Q_W-1:0] t_s   [C_W];
	lane_tag_t      tag_s [C_W];
	logic [C_W-1:0] vld_s;

	for (genvar g = 0; g < C_W; g++) begin : g_stage
		logic [C_W-1:0]   mprev;
		logic [Q_W-1:0]   tprev;
		lane_tag_t        gprev;
		logic             vprev;
		logic [C_W-1:0]   cand;
		logic [ODD_W-1:0] odd;
		logic [SQ_W-1:0]  sq;

		if (g == 0) begin : g_first
			assign mprev = '0;
			assign tprev = t;
			assign gprev = in_tag;
			assign vprev = in_vld;
		end else begin : g_next
			assign mprev = mg_s[g-1];
			assign tprev = t_s[g-1];
			assign gprev = tag_s[g-1];
			assign vprev = vld_s[g-1];
		end

		assign cand = mprev | (C_W'(1) << (C_W - 1 - g));
		assign odd  = {cand, 1'b0} - ODD_W'(1);
		assign sq   = SQ_W'(odd) * SQ_W'(odd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vprev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mg_s[g]  <= (sq <= SQ_W'(tprev)) ? cand : mprev;
				t_s[g]   <= tprev;
				tag_s[g] <= gprev;
			end
		end
	end

	assign out_vld = vld_s[C_W-1];
	assign mag     = mg_s[C_W-1];
	assign out_tag = tag_s[C_W-1];

endmodule

// ===== rtl/normalized_quaternion_multiply.sv =====
// An accepted pair flows through the front, divide, root and output pipeline sections to the result word.
// Throughput: one pair per cycle while the output is not stalled; every stage is a full pipeline register.
// A stall on the output freezes the whole pipeline in place.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
`include "normalized_quaternion_multiply_macros.svh"
module normalized_quaternion_multiply import nqm_pkg::*; #(
	parameter int COMP_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	nqm_pair_if.sink   pair,
	nqm_prod_if.source prod
);

	localparam int NW = 4 * COMP_WIDTH + 1;

	logic                         en;
	logic signed [COMP_WIDTH-1:0] qv [4];
	logic signed [COMP_WIDTH-1:0] pv [4];

	logic          fr_vld;
	logic [NW-1:0] fr_m;
	logic [NW-1:0] fr_h2 [4];
	lane_tag_t     fr_tag [4];

	logic           dv_vld [4];
	logic [Q_W-1:0] dv_quo [4];
	lane_tag_t      dv_tag [4];

	logic           sq_vld [4];
	logic [C_W-1:0] sq_mag [4];
	lane_tag_t      sq_tag [4];

	logic signed [OUT_W-1:0] res_s1 [4];
	logic                    zn_s1;
	logic                    vld_s1;

	logic lanes_agree;
	logic in_range;
	logic res_zero;

	assign en         = !vld_s1 || prod.ready;
	assign pair.ready = en;

	assign qv[0] = pair.q_w;
	assign qv[1] = pair.q_x;
	assign qv[2] = pair.q_y;
	assign qv[3] = pair.q_z;
	assign pv[0] = pair.p_w;
	assign pv[1] = pair.p_x;
	assign pv[2] = pair.p_y;
	assign pv[3] = pair.p_z;

	nqm_front #(.W(COMP_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (pair.valid),
		.q       (qv),
		.p       (pv),
		.out_vld (fr_vld),
		.m       (fr_m),
		.h2      (fr_h2),
		.tag     (fr_tag)
	);

	for (genvar k = 0; k < 4; k++) begin : g_lane
		nqm_div #(.W(COMP_WIDTH)) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (fr_vld),
			.num     (fr_h2[k]),
			.den     (fr_m),
			.in_tag  (fr_tag[k]),
			.out_vld (dv_vld[k]),
			.quo     (dv_quo[k]),
			.out_tag (dv_tag[k])
		);

		nqm_sqrt u_sqrt (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (dv_vld[k]),
			.t       (dv_quo[k]),
			.in_tag  (dv_tag[k]),
			.out_vld (sq_vld[k]),
			.mag     (sq_mag[k]),
			.out_tag (sq_tag[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		logic [OUT_W-1:0] mg;
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				mg = (OUT_W'(sq_mag[k]) > UNIT_MAG) ? UNIT_MAG : OUT_W'(sq_mag[k]);
				if (sq_tag[k].zn) begin
					res_s1[k] <= '0;
				end else begin
					res_s1[k] <= sq_tag[k].neg ? -$signed(mg) : $signed(mg);
				end
			end
			zn_s1 <= sq_tag[0].zn;
		end
	end

	assign prod.valid     = vld_s1;
	assign prod.r_w       = res_s1[0];
	assign prod.r_x       = res_s1[1];
	assign prod.r_y       = res_s1[2];
	assign prod.r_z       = res_s1[3];
	assign prod.zero_norm = zn_s1;

	assign lanes_agree = (sq_vld[0] == sq_vld[1]) && (sq_vld[0] == sq_vld[2])
		&& (sq_vld[0] == sq_vld[3]) && (dv_vld[0] == dv_vld[3]);
	always_comb begin
		in_range = 1'b1;
		res_zero = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if ((res_s1[k] > UNIT_POS) || (res_s1[k] < UNIT_NEG)) begin
				in_range = 1'b0;
			end
			if (res_s1[k] != '0) begin
				res_zero = 1'b0;
			end
		end
	end

	`NQM_ASSERT(a_lanes_agree, lanes_agree)
	`NQM_ASSERT_IMP(a_unit_range, vld_s1, in_range)
	`NQM_ASSERT_IMP(a_zero_norm_result, vld_s1 && zn_s1, res_zero)

endmodule
